/* rtl/core/disk_scan_cscan_scheduler_macros.svh */
// assertion macros for the disk scan scheduler
// used by files that assert; expects clk and rst_n in scope
`ifndef DISK_SCAN_CSCAN_SCHEDULER_MACROS_SVH
`define DISK_SCAN_CSCAN_SCHEDULER_MACROS_SVH

// property that holds on every clock outside reset
`define DSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication
`define DSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dsc_pkg.sv */
// shared types and constants of the disk scan scheduler
// no dependencies
`default_nettype none

package dsc_pkg;

  localparam int CYL_W       = 16;
  localparam int TOT_W       = 22;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - TOT_W - CYL_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TOT_W-1:0] TOT_MAX = 22'd4194303;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd2;

  // register reset values
  localparam logic             MODE_RST = 1'b0;
  localparam logic             DIR_RST  = 1'b1;
  localparam logic [CYL_W-1:0] SIZE_RST = 16'd200;

  // codes
  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_RUN     = 1'b1;
  localparam logic MODE_SCAN  = 1'b0;
  localparam logic MODE_CSCAN = 1'b1;
  localparam logic DIR_UP     = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_TURN  = 6'b001000,
    ST_JUMP  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [TOT_W-1:0] total;
  } res_t;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic emit;
    logic flush;
    res_t res;
  } oreq_t;

  // result stage status back to the sequencer
  typedef struct packed {
    logic emit_ok;
    logic flush_ok;
  } ostat_t;

endpackage

`default_nettype wire

/* rtl/core/dsc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/dsc_sel.sv */
// selection unit: keeps the smallest or largest key inside a window
// over one pass of the request store; uses dsc_pkg
`default_nettype none

module dsc_sel #(
  parameter int KW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          cmp_vld,
  input  wire logic          asc,
  input  wire logic [KW:0]   lo,
  input  wire logic [KW:0]   hi,
  input  wire logic [KW-1:0] cand,
  output logic               found,
  output logic [KW-1:0]      best
);

  import dsc_pkg::*;

  logic          found_r, found_nxt;
  logic [KW-1:0] best_r, best_nxt;
  logic          in_rng;
  logic          better;

  // window test and ordering against the current best
  always_comb begin
    in_rng    = ({1'b0, cand} >= lo) && ({1'b0, cand} < hi);
    better    = !found_r || (asc ? (cand < best_r) : (cand > best_r));
    found_nxt = found_r;
    best_nxt  = best_r;
    if (clr) begin
      found_nxt = 1'b0;
    end else if (cmp_vld && in_rng && better) begin
      found_nxt = 1'b1;
      best_nxt  = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign found = found_r;
  assign best  = best_r;

endmodule

`default_nettype wire

/* rtl/core/dsc_out.sv */
// result stage: one pending slot that waits until the next result or the
// end of the run decides its last flag, then the output register; uses dsc_pkg
`default_nettype none

module dsc_out (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dsc_pkg::oreq_t                  req,
  output dsc_pkg::ostat_t                      stat,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [dsc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  import dsc_pkg::*;

  logic pend_vld_r, pend_vld_nxt;
  res_t pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  res_t out_r, out_nxt;
  logic last_r, last_nxt;
  logic out_free;

  assign out_free      = !out_vld_r || out_tready;
  assign stat.emit_ok  = !pend_vld_r || out_free;
  assign stat.flush_ok = out_free;

  // move pending result forward on a new result or at the end of the run
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_nxt      = out_r;
    last_nxt     = last_r;
    if (req.emit && stat.emit_ok) begin
      if (pend_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = pend_r;
        last_nxt    = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = req.res;
    end else if (req.flush && out_free) begin
      out_vld_nxt  = 1'b1;
      out_nxt      = pend_vld_r ? pend_r : req.res;
      last_nxt     = 1'b1;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r.total, out_r.cyl};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

/* rtl/core/disk_scan_cscan_scheduler.sv */
// Disk head scheduler (SCAN / C-SCAN), top level.
// Input stream: in_tuser = opcode (0 append request, 1 run), in_tdata = cylinder.
// An append stores the cylinder; appends beyond MAX_REQ
// are dropped. A run takes the head position and walks the stored requests.
// Output stream: one request per head move, out_tdata = visit cylinder and
// running total, out_tlast on the final move of the run.
// Each visited request costs one selection pass over the store memory, which
// reads one request a cycle through the registered read port and then decides.
// Each sweep ends with one more pass; the turn point, the jump (C-SCAN only) and
// the final flush follow as states of their own. Inputs are not taken while a
// run is in progress.
// A result is held one stage until the next one decides its last flag.
// When out_tready is low the sequencer stalls at the next move; nothing is lost.
// Reset (rst_n low, synchronous) clears the request count and the output
// stage; the store itself needs no clearing. Configuration writes are taken
// in any cycle and are meant for an idle block.
`default_nettype none
`include "disk_scan_cscan_scheduler_macros.svh"

module disk_scan_cscan_scheduler #(
  parameter int MAX_REQ = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dsc_pkg::CYL_W-1:0]        in_tdata,   // [15:0] cylinder
  input  wire logic                             in_tuser,   // [0] opcode
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [dsc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [15:0] visit_cylinder,
                                                            // [37:16] total_movement
  output logic                                  out_tlast,  // last
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsc_pkg::CYL_W-1:0]        cfg_data
);

  import dsc_pkg::*;

  localparam int IW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
  localparam int CW = $clog2(MAX_REQ + 1);
  localparam int KW = CYL_W + IW;

  // configuration
  logic             mode_r;
  logic             dir_r;
  logic [CYL_W-1:0] size_r;

  // sequencer state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [KW:0]      lo_r, lo_nxt;
  logic [KW:0]      hi_r, hi_nxt;
  logic             asc_r, asc_nxt;
  logic             second_r, second_nxt;
  logic [CYL_W-1:0] run_cyl_r, run_cyl_nxt;
  logic [CYL_W-1:0] head_r, head_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  // memory and selection unit
  logic             mem_wr_en;
  logic             mem_rd_en;
  logic [CYL_W-1:0] mem_rd_data;
  logic             sel_clr;
  logic             sel_found;
  logic [KW-1:0]    sel_best;
  logic [CYL_W-1:0] best_cyl;

  // move and result stage
  logic             emit_vld;
  logic [CYL_W-1:0] emit_cyl;
  logic             emit_jump;
  logic             emit_fire;
  logic             start_second;
  logic             go;
  logic [CYL_W-1:0] end_cyl;
  logic [CYL_W-1:0] target_cyl;
  logic [CYL_W-1:0] move_dist;
  logic [CYL_W-1:0] cost;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] total_new;
  logic [KW:0]      key_in;
  logic [KW:0]      key_run;
  logic [KW:0]      key_inf;
  oreq_t            oreq;
  ostat_t           ostat;

  assign end_cyl  = size_r - 16'd1;
  assign key_in   = {1'b0, in_tdata, {IW{1'b0}}};
  assign key_run  = {1'b0, run_cyl_r, {IW{1'b0}}};
  assign key_inf  = {1'b1, {KW{1'b0}}};
  assign best_cyl = sel_best[KW-1:IW];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // request store; writes only in idle, reads only while scanning
  dsc_ram #(
    .WIDTH (CYL_W),
    .DEPTH (MAX_REQ)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (cnt_r[IW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_cnt_r[IW-1:0]),
    .rd_data (mem_rd_data)
  );

  dsc_sel #(
    .KW (KW)
  ) u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (sel_clr),
    .cmp_vld (cmp_vld_r),
    .asc     (asc_r),
    .lo      (lo_r),
    .hi      (hi_r),
    .cand    ({mem_rd_data, cmp_idx_r}),
    .found   (sel_found),
    .best    (sel_best)
  );

  dsc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (oreq),
    .stat       (ostat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // movement of the next move and saturating running total
  always_comb begin
    move_dist = (emit_cyl >= head_r) ? (emit_cyl - head_r) : (head_r - emit_cyl);
    cost      = emit_jump ? end_cyl : move_dist;
    sum       = {1'b0, total_r} + (TOT_W + 1)'(cost);
    total_new = (sum > {1'b0, TOT_MAX}) ? TOT_MAX : sum[TOT_W-1:0];
  end

  assign emit_fire = emit_vld && ostat.emit_ok;

  always_comb begin
    oreq.emit  = emit_vld;
    oreq.flush = (state_r == ST_FLUSH);
    if (state_r == ST_FLUSH) begin
      oreq.res.cyl   = run_cyl_r;
      oreq.res.total = '0;
    end else begin
      oreq.res.cyl   = emit_cyl;
      oreq.res.total = total_new;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = scan_cnt_r[IW-1:0];
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    asc_nxt      = asc_r;
    second_nxt   = second_r;
    run_cyl_nxt  = run_cyl_r;
    head_nxt     = head_r;
    total_nxt    = total_r;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    sel_clr      = 1'b0;
    emit_vld     = 1'b0;
    emit_cyl     = best_cyl;
    emit_jump    = 1'b0;
    start_second = 1'b0;
    go           = 1'b0;
    target_cyl   = (dir_r == DIR_UP) ? end_cyl : '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_APPEND) begin
            if (cnt_r < CW'(MAX_REQ)) begin
              mem_wr_en = 1'b1;
              cnt_nxt   = cnt_r + CW'(1);
            end
          end else begin
            run_cyl_nxt  = in_tdata;
            head_nxt     = in_tdata;
            total_nxt    = '0;
            second_nxt   = 1'b0;
            asc_nxt      = dir_r;
            lo_nxt       = (dir_r == DIR_UP) ? key_in : '0;
            hi_nxt       = (dir_r == DIR_UP) ? key_inf : key_in;
            scan_cnt_nxt = '0;
            sel_clr      = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one read a cycle, compared in the next cycle
        if (scan_cnt_r < cnt_r) begin
          mem_rd_en    = 1'b1;
          cmp_vld_nxt  = 1'b1;
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sel_found) begin
          emit_vld = 1'b1;
          if (ostat.emit_ok) begin
            if (asc_r) begin
              lo_nxt = {1'b0, sel_best} + (KW + 1)'(1);
            end else begin
              hi_nxt = {1'b0, sel_best};
            end
            scan_cnt_nxt = '0;
            sel_clr      = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end else if (!second_r) begin
          state_nxt = ST_TURN;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_TURN: begin
        // turn point at the disk end, skipped when the head is there
        emit_cyl = target_cyl;
        if (head_r != target_cyl) begin
          emit_vld = 1'b1;
          go       = ostat.emit_ok;
        end else begin
          go = 1'b1;
        end
        if (go) begin
          if (mode_r == MODE_CSCAN) begin
            state_nxt = ST_JUMP;
          end else begin
            start_second = 1'b1;
          end
        end
      end
      ST_JUMP: begin
        // wrap to the opposite end, always charged as a full stroke
        emit_cyl  = (dir_r == DIR_UP) ? '0 : end_cyl;
        emit_jump = 1'b1;
        emit_vld  = 1'b1;
        if (ostat.emit_ok) begin
          start_second = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (ostat.flush_ok) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // second sweep window
    if (start_second) begin
      second_nxt   = 1'b1;
      asc_nxt      = ~(dir_r ^ mode_r);
      lo_nxt       = (dir_r == DIR_UP) ? '0 : key_run;
      hi_nxt       = (dir_r == DIR_UP) ? key_run : key_inf;
      scan_cnt_nxt = '0;
      sel_clr      = 1'b1;
      state_nxt    = ST_SCAN;
    end

    if (emit_fire) begin
      head_nxt  = emit_cyl;
      total_nxt = total_new;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      mode_r    <= MODE_RST;
      dir_r     <= DIR_RST;
      size_r    <= SIZE_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: mode_r <= cfg_data[0];
          REG_DIR:  dir_r  <= cfg_data[0];
          REG_SIZE: size_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // run registers, loaded before use
  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    asc_r      <= asc_nxt;
    second_r   <= second_nxt;
    run_cyl_r  <= run_cyl_nxt;
    head_r     <= head_nxt;
    total_r    <= total_nxt;
  end

  // checks
  `DSC_ASSERT_IMP(a_no_rw_overlap, mem_wr_en, !mem_rd_en, "store written during a scan")
  `DSC_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_REQ), "request count beyond capacity")
  `DSC_ASSERT_IMP(a_scan_bound, state_r == ST_SCAN, scan_cnt_r <= cnt_r, "scan past count")
  `DSC_ASSERT_NXT(a_flush_last, (state_r == ST_FLUSH) && ostat.flush_ok, out_tvalid && out_tlast, "run end without last")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the SCAN / C-SCAN disk head scheduler
// depends on dsc_pkg and disk_scan_cscan_scheduler; reads no files

module testbench;
  import dsc_pkg::*;

  localparam int   STORE_DEPTH   = 32;
  localparam int   IDLE_LIMIT    = 5000;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   ITEM_TARGET   = 500;
  localparam int   CALM_ITEMS    = 440;
  localparam int   PHASE_ITEMS   = 45;
  localparam int   SHOW_ERRORS   = 10;
  localparam logic DIR_DOWN      = ~DIR_UP;

  // one expected head move
  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [TOT_W-1:0] total;
    logic             is_last;
  } move_t;

  // tracks stored requests and registers, predicts the visit order of each run
  class sweep_scoreboard;
    logic             mode;
    logic             dir;
    logic [CYL_W-1:0] disk_cyls;
    logic [CYL_W-1:0] store [STORE_DEPTH];
    int               stored;
    logic [CYL_W-1:0] head;
    int unsigned      travel;
    move_t            planned [$];
    int               errors;

    function new();
      mode      = MODE_RST;
      dir       = DIR_RST;
      disk_cyls = SIZE_RST;
      stored    = 0;
      errors    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CYL_W-1:0] data);
      case (idx)
        REG_MODE: mode = data[0];
        REG_DIR:  dir = data[0];
        REG_SIZE: disk_cyls = data;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return planned.size();
    endfunction

    function int unsigned distance(logic [CYL_W-1:0] cyl);
      return (cyl > head) ? 32'(cyl - head) : 32'(head - cyl);
    endfunction

    // head moves to cyl at the given cost, total saturates
    function void add_move(logic [CYL_W-1:0] cyl, int unsigned cost);
      move_t m;
      travel = travel + cost;
      if (travel > 32'(TOT_MAX)) travel = 32'(TOT_MAX);
      head      = cyl;
      m.cyl     = cyl;
      m.total   = travel[TOT_W-1:0];
      m.is_last = 1'b0;
      planned.push_back(m);
    endfunction

    // sort, split at the head and walk the sweep
    function void plan_sweep(logic [CYL_W-1:0] start);
      logic [CYL_W-1:0] sorted [STORE_DEPTH];
      logic [CYL_W-1:0] v;
      logic [CYL_W-1:0] end_cyl;
      move_t            m;
      int               n, split, i, j, first_idx;
      n = stored;
      for (i = 0; i < n; i++) begin
        v = store[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      // requests equal to the head go with the upward group
      split = 0;
      while (split < n && sorted[split] < start) split++;
      end_cyl   = disk_cyls - 1'b1;
      first_idx = planned.size();
      head      = start;
      travel    = 0;
      if (dir == DIR_UP) begin
        for (i = split; i < n; i++) add_move(sorted[i], distance(sorted[i]));
        if (head != end_cyl) add_move(end_cyl, distance(end_cyl));
        if (mode == MODE_SCAN) begin
          for (i = split - 1; i >= 0; i--) add_move(sorted[i], distance(sorted[i]));
        end else begin
          // jump back to cylinder zero costs the current position
          add_move(16'd0, 32'(head));
          for (i = 0; i < split; i++) add_move(sorted[i], distance(sorted[i]));
        end
      end else begin
        for (i = split - 1; i >= 0; i--) add_move(sorted[i], distance(sorted[i]));
        if (head != 16'd0) add_move(16'd0, distance(16'd0));
        if (mode == MODE_SCAN) begin
          for (i = split; i < n; i++) add_move(sorted[i], distance(sorted[i]));
        end else begin
          add_move(end_cyl, 32'(end_cyl));
          for (i = n - 1; i >= split; i--) add_move(sorted[i], distance(sorted[i]));
        end
      end
      // nothing to visit: the head itself with zero movement
      if (planned.size() == first_idx) add_move(start, 0);
      m = planned.pop_back();
      m.is_last = 1'b1;
      planned.push_back(m);
      stored = 0;
    endfunction

    function void note_request(logic op, logic [CYL_W-1:0] cyl);
      if (op == OP_APPEND) begin
        // a full store drops the request
        if (stored < STORE_DEPTH) begin
          store[stored] = cyl;
          stored++;
        end
      end else begin
        plan_sweep(cyl);
      end
    endfunction

    function void check_result(logic [CYL_W-1:0] cyl, logic [TOT_W-1:0] total,
                               logic is_last, logic [OUT_PAD_W-1:0] pad);
      move_t want;
      if (planned.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("unexpected result: cyl %0d total %0d last %0b", cyl, total, is_last);
        return;
      end
      want = planned.pop_front();
      if (cyl !== want.cyl || total !== want.total || is_last !== want.is_last ||
          pad !== '0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("mismatch: expected cyl %0d total %0d last %0b, got cyl %0d total %0d last %0b pad %0h",
                   want.cyl, want.total, want.is_last, cyl, total, is_last, pad);
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [CYL_W-1:0]       in_tdata   = '0;
  logic                   in_tuser   = OP_APPEND;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CYL_W-1:0]       cfg_data   = '0;

  sweep_scoreboard  sb = new();
  bit               calm        = 1'b0;
  bit               hold_wanted = 1'b0;
  bit               gaps_on     = 1'b0;
  int               items_sent  = 0;
  int               idle_cycles = 0;
  logic [CYL_W-1:0] cur_size    = SIZE_RST;

  disk_scan_cscan_scheduler #(
    .MAX_REQ    (STORE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // handshakes seen at the rising edge feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[CYL_W-1:0], out_tdata[CYL_W+TOT_W-1:CYL_W], out_tlast,
                        out_tdata[OUT_TDATA_W-1:CYL_W+TOT_W]);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("disk_scan_cscan_scheduler test failed");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int window;
    bit held;
    bit stalls_on;
    stall_left = 0;
    window     = 0;
    held       = 1'b0;
    stalls_on  = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_wanted && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      window++;
      if (window >= 150) begin
        window    = 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (stalls_on && !calm && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 9);
      end
    end
  end

  // one request on the input stream, with an optional gap in front
  task automatic send_request(logic op, logic [CYL_W-1:0] cyl);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= cyl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // wait until every expected move has come out and the block has settled
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CYL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic mode, logic dir, logic [CYL_W-1:0] cyls);
    write_reg(REG_MODE, {{(CYL_W-1){1'b0}}, mode});
    write_reg(REG_DIR, {{(CYL_W-1){1'b0}}, dir});
    write_reg(REG_SIZE, cyls);
    cfg_valid <= 1'b0;
    cur_size = cyls;
  endtask

  // cylinder mix: edges, the head itself, beyond the end, anywhere on the disk
  function automatic logic [CYL_W-1:0] pick_cylinder(logic [CYL_W-1:0] head);
    logic [CYL_W-1:0] end_cyl;
    end_cyl = cur_size - 1'b1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return end_cyl;
      2:       return 16'd65534;
      3:       return head;
      4, 5:    return CYL_W'($urandom_range(0, 65534));
      default: return CYL_W'($urandom_range(0, 32'(end_cyl)));
    endcase
  endfunction

  // a run of appends closed by a run request
  task automatic run_batch(int n_req);
    logic [CYL_W-1:0] head;
    head = pick_cylinder(CYL_W'($urandom_range(0, 65534)));
    repeat (n_req) send_request(OP_APPEND, pick_cylinder(head));
    send_request(OP_RUN, head);
  endtask

  initial begin : stimulus
    int               phase;
    int               batch;
    int               phase_items;
    int               start_count;
    int               n_req;
    logic             mode;
    logic             dir;
    logic [CYL_W-1:0] cyls;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: scan upward on 200 cylinders
    send_request(OP_RUN, 16'd199);      // empty store, head already at the turn point
    send_request(OP_APPEND, 16'd50);
    send_request(OP_APPEND, 16'd150);
    send_request(OP_APPEND, 16'd100);
    send_request(OP_APPEND, 16'd0);
    send_request(OP_RUN, 16'd100);      // request equal to head counts as upward
    send_request(OP_RUN, 16'd0);        // empty store, sweep to the end only
    drain_results();

    // scan downward on the smallest disk, requests beyond the end
    apply_settings(MODE_SCAN, DIR_DOWN, 16'd2);
    send_request(OP_RUN, 16'd0);
    send_request(OP_APPEND, 16'd65534);
    send_request(OP_APPEND, 16'd1);
    send_request(OP_RUN, 16'd1);
    drain_results();

    // c-scan upward on the largest disk
    apply_settings(MODE_CSCAN, DIR_UP, 16'd65535);
    send_request(OP_APPEND, 16'd65534);
    send_request(OP_APPEND, 16'd0);
    send_request(OP_RUN, 16'd30000);
    send_request(OP_APPEND, 16'd65534);
    send_request(OP_RUN, 16'd65534);    // head at the end already
    drain_results();

    // c-scan downward on the smallest disk
    apply_settings(MODE_CSCAN, DIR_DOWN, 16'd2);
    send_request(OP_APPEND, 16'd5);
    send_request(OP_APPEND, 16'd0);
    send_request(OP_RUN, 16'd3);
    send_request(OP_RUN, 16'd0);

    // random phases, each with its own settings
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      if (phase < 4) begin
        mode = phase[0];
        dir  = phase[1];
        cyls = phase[0] ? 16'd65535 : 16'd2;
      end else begin
        mode = 1'($urandom_range(0, 1));
        dir  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0:       cyls = 16'd2;
          1:       cyls = 16'd65535;
          2:       cyls = SIZE_RST;
          3:       cyls = CYL_W'($urandom_range(2, 64));
          default: cyls = CYL_W'($urandom_range(2, 65535));
        endcase
      end
      apply_settings(mode, dir, cyls);
      phase_items = 0;
      batch       = 0;
      while (phase_items < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        calm        = (items_sent >= CALM_ITEMS);
        gaps_on     = $urandom_range(0, 2) != 0;
        start_count = items_sent;
        if (phase == 0 && batch == 0) begin
          // overfill the store once early on
          run_batch(STORE_DEPTH + 3);
        end else if ($urandom_range(0, 9) == 0) begin
          // noise: any opcode, any cylinder
          repeat ($urandom_range(1, 4))
            send_request(1'($urandom_range(0, 1)), CYL_W'($urandom_range(0, 65534)));
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    n_req = $urandom_range(9, STORE_DEPTH - 1);
            2:       n_req = $urandom_range(STORE_DEPTH, STORE_DEPTH + 4);
            default: n_req = $urandom_range(0, 8);
          endcase
          run_batch(n_req);
        end
        // long result hold-off while the next requests keep coming
        if (phase == 1 && batch == 0) hold_wanted <= 1'b1;
        phase_items += items_sent - start_count;
        batch++;
      end
      phase++;
    end

    drain_results();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("disk_scan_cscan_scheduler test passed");
    end else begin
      $display("disk_scan_cscan_scheduler test failed");
    end
    $finish;
  end

endmodule
